### rtl/dsi_pkg.sv
// Package: types, codes and reset constants for the device safety interlock.
package dsi_pkg;

  typedef enum logic [2:0] {
    ST_STANDBY = 3'd0,
    ST_CALIB   = 3'd1,
    ST_READY   = 3'd2,
    ST_ACTIVE  = 3'd3,
    ST_FAULT   = 3'd4,
    ST_ESTOP   = 3'd5
  } state_t;

  typedef enum logic [2:0] {
    FN_START_DEV  = 3'd0,
    FN_START_PROC = 3'd1,
    FN_STOP_PROC  = 3'd2,
    FN_ACK_FAULT  = 3'd3,
    FN_CLR_ESTOP  = 3'd4,
    FN_SENSOR     = 3'd5,
    FN_EXT_FAULT  = 3'd6
  } func_t;

  typedef enum logic [1:0] {
    CAUSE_NONE     = 2'd0,
    CAUSE_OT_STOP  = 2'd1,
    CAUSE_OT_FAULT = 2'd2,
    CAUSE_EXT      = 2'd3
  } cause_t;

  localparam logic [1:0] REG_CAL_TICKS  = 2'd0;
  localparam logic [1:0] REG_MAX_FAULTS = 2'd1;
  localparam logic [1:0] REG_FAULT_TEMP = 2'd2;
  localparam logic [1:0] REG_STOP_TEMP  = 2'd3;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [15:0]        CAL_TICKS_RST  = 16'd10;
  localparam logic [7:0]         MAX_FAULTS_RST = 8'd3;
  localparam logic signed [15:0] FAULT_TEMP_RST = 16'sd960;   // 60.0 deg
  localparam logic signed [15:0] STOP_TEMP_RST  = 16'sd1200;  // 75.0 deg

  typedef struct packed {
    logic [15:0]        cal_ticks;
    logic [7:0]         max_faults;
    logic signed [15:0] fault_temp;
    logic signed [15:0] stop_temp;
  } cfg_t;

  typedef struct packed {
    state_t      state;
    logic [15:0] calib_cnt;
    logic [7:0]  faults;
    logic        sess_open;
  } ctx_t;

  typedef struct packed {
    ctx_t   ctx;
    logic   changed;
    logic   started;
    cause_t cause;
  } step_t;

endpackage

### rtl/dsi_if.sv
// Valid/ready channel interfaces for events and results.
interface dsi_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         func;
  logic signed [15:0] temperature;

  modport source (output valid, output func, output temperature, input ready);
  modport sink   (input valid, input func, input temperature, output ready);
endinterface

interface dsi_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] device_state;
  logic       state_changed;
  logic       session_started;
  logic [7:0] fault_count;
  logic [1:0] fault_cause;

  modport source (output valid, output device_state, output state_changed,
                  output session_started, output fault_count, output fault_cause,
                  input ready);
  modport sink   (input valid, input device_state, input state_changed,
                  input session_started, input fault_count, input fault_cause,
                  output ready);
endinterface

### rtl/dsi_step.sv
// Interlock transition logic: next state, counters and result flags for one event.
module dsi_step (
  input  dsi_pkg::ctx_t      cur,
  input  dsi_pkg::cfg_t      cfg,
  input  logic [2:0]         func,
  input  logic signed [15:0] temperature,
  output dsi_pkg::step_t     res
);
  import dsi_pkg::*;

  func_t       fn;
  logic [7:0]  faults_inc;
  logic [15:0] calib_inc;
  state_t      fault_dest;
  state_t      state_nxt;

  assign fn         = func_t'(func);
  assign faults_inc = (cur.faults == 8'hFF) ? cur.faults : cur.faults + 8'd1;
  assign calib_inc  = (cur.calib_cnt == 16'hFFFF) ? cur.calib_cnt : cur.calib_cnt + 16'd1;
  assign fault_dest = (faults_inc >= cfg.max_faults) ? ST_ESTOP : ST_FAULT;

  // next state
  always_comb begin
    state_nxt = cur.state;
    case (fn)
      FN_START_DEV:  if (cur.state == ST_STANDBY) state_nxt = ST_CALIB;
      FN_START_PROC: if (cur.state == ST_READY)   state_nxt = ST_ACTIVE;
      FN_STOP_PROC:  if (cur.state == ST_ACTIVE)  state_nxt = ST_READY;
      FN_ACK_FAULT:  if (cur.state == ST_FAULT)   state_nxt = ST_STANDBY;
      FN_CLR_ESTOP:  if (cur.state == ST_ESTOP)   state_nxt = ST_STANDBY;
      FN_SENSOR: begin
        if (cur.state == ST_CALIB) begin
          if (calib_inc >= cfg.cal_ticks) state_nxt = ST_READY;
        end else if (cur.state == ST_ACTIVE) begin
          if (temperature > cfg.stop_temp)       state_nxt = ST_ESTOP;
          else if (temperature > cfg.fault_temp) state_nxt = fault_dest;
        end
      end
      FN_EXT_FAULT: begin
        if (cur.state == ST_ACTIVE || cur.state == ST_CALIB) state_nxt = fault_dest;
      end
      default: state_nxt = cur.state;
    endcase
  end

  // counters and flags
  always_comb begin
    res.ctx       = cur;
    res.ctx.state = state_nxt;
    res.changed   = (state_nxt != cur.state);
    res.started   = 1'b0;
    res.cause     = CAUSE_NONE;
    case (fn)
      FN_START_DEV: begin
        if (cur.state == ST_STANDBY) begin
          res.ctx.calib_cnt = '0;
          if (!cur.sess_open) begin
            res.ctx.sess_open = 1'b1;
            res.ctx.faults    = '0;
            res.started       = 1'b1;
          end
        end
      end
      FN_CLR_ESTOP: begin
        if (cur.state == ST_ESTOP) begin
          res.ctx.sess_open = 1'b0;
          res.ctx.faults    = '0;
        end
      end
      FN_SENSOR: begin
        if (cur.state == ST_CALIB) begin
          res.ctx.calib_cnt = calib_inc;
        end else if (cur.state == ST_ACTIVE) begin
          if (temperature > cfg.stop_temp) begin
            res.cause = CAUSE_OT_STOP;
          end else if (temperature > cfg.fault_temp) begin
            res.cause      = CAUSE_OT_FAULT;
            res.ctx.faults = faults_inc;
          end
        end
      end
      FN_EXT_FAULT: begin
        if (cur.state == ST_ACTIVE || cur.state == ST_CALIB) begin
          res.cause      = CAUSE_EXT;
          res.ctx.faults = faults_inc;
        end
      end
      default: res.cause = CAUSE_NONE;
    endcase
  end

endmodule

### rtl/device_safety_interlock_fsm_top.sv
// Top level of the device safety interlock: event register, state, result register.
//
//  channel  | dir | handshake     | payload
//  in_ch    | in  | valid/ready   | func[2:0], temperature[15:0] signed
//  out_ch   | out | valid/ready   | device_state, state_changed, session_started,
//           |     |               | fault_count[7:0], fault_cause[1:0]
//  cfg_*    | in  | we, no ready  | cfg_idx[1:0], cfg_wdata[15:0]
//
// One event per cycle while results are taken; results come from the result register.
// The interlock state updates as an event moves from the input register to the
// result register, so each event sees the one before it without a bubble.
// A stalled result holds both registers; the input accepts while its register is
// free or drains this cycle. Reset clears state, counters, valids; loads default config.
module device_safety_interlock_fsm_top (
  input  logic                               clk,
  input  logic                               rst_n,
  dsi_in_if.sink                             in_ch,
  dsi_out_if.source                          out_ch,
  input  logic                               cfg_we,
  input  logic [dsi_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  logic [dsi_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import dsi_pkg::*;

  cfg_t               cfg_r;
  ctx_t               ctx_r;
  step_t              step;

  logic               ev_valid_r;
  logic [2:0]         ev_func_r;
  logic signed [15:0] ev_temp_r;

  logic               out_valid_r;
  state_t             out_state_r;
  logic               out_changed_r;
  logic               out_started_r;
  logic [7:0]         out_faults_r;
  cause_t             out_cause_r;

  logic               adv;

  assign adv         = ev_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !ev_valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.cal_ticks  <= CAL_TICKS_RST;
      cfg_r.max_faults <= MAX_FAULTS_RST;
      cfg_r.fault_temp <= FAULT_TEMP_RST;
      cfg_r.stop_temp  <= STOP_TEMP_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_CAL_TICKS:  cfg_r.cal_ticks  <= cfg_wdata;
        REG_MAX_FAULTS: cfg_r.max_faults <= cfg_wdata[7:0];
        REG_FAULT_TEMP: cfg_r.fault_temp <= cfg_wdata;
        REG_STOP_TEMP:  cfg_r.stop_temp  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ev_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      ev_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      ev_func_r <= in_ch.func;
      ev_temp_r <= in_ch.temperature;
    end
  end

  dsi_step u_step (
    .cur         (ctx_r),
    .cfg         (cfg_r),
    .func        (ev_func_r),
    .temperature (ev_temp_r),
    .res         (step)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctx_r.state     <= ST_STANDBY;
      ctx_r.calib_cnt <= '0;
      ctx_r.faults    <= '0;
      ctx_r.sess_open <= 1'b0;
    end else if (adv) begin
      ctx_r <= step.ctx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_state_r   <= step.ctx.state;
      out_changed_r <= step.changed;
      out_started_r <= step.started;
      out_faults_r  <= step.ctx.faults;
      out_cause_r   <= step.cause;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.device_state    = out_state_r;
  assign out_ch.state_changed   = out_changed_r;
  assign out_ch.session_started = out_started_r;
  assign out_ch.fault_count     = out_faults_r;
  assign out_ch.fault_cause     = out_cause_r;

  // the pending result always reflects the live interlock state
  a_out_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_state_r == ctx_r.state && out_faults_r == ctx_r.faults))
    else $error("result state differs from interlock state");

  a_faults_need_session: assert property (@(posedge clk) disable iff (!rst_n)
    (ctx_r.faults != 8'd0) |-> ctx_r.sess_open)
    else $error("fault count outside an open session");

  a_start_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_started_r) |->
      (out_state_r == ST_CALIB && out_faults_r == 8'd0 && out_changed_r))
    else $error("session start with bad state or count");

  a_ot_stop_estop: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_cause_r == CAUSE_OT_STOP) |-> (out_state_r == ST_ESTOP))
    else $error("overtemperature stop without emergency stop");

endmodule
